[hw/rtl/rvie_pkg.sv]
package rvie_pkg;

  localparam logic [5:0] GROUP_CMP = 6'h10;
  localparam logic [5:0] GROUP_MEM = 6'h20;
  localparam logic [5:0] GROUP_JMP = 6'h30;

  localparam logic [5:0] OP_ADD  = 6'h01;
  localparam logic [5:0] OP_SUB  = 6'h02;
  localparam logic [5:0] OP_MUL  = 6'h03;
  localparam logic [5:0] OP_DIV  = 6'h04;
  localparam logic [5:0] OP_MOD  = 6'h05;
  localparam logic [5:0] OP_AND  = 6'h06;
  localparam logic [5:0] OP_OR   = 6'h07;
  localparam logic [5:0] OP_XOR  = 6'h08;
  localparam logic [5:0] OP_SHL  = 6'h09;
  localparam logic [5:0] OP_SHR  = 6'h0A;
  localparam logic [5:0] OP_LT   = GROUP_CMP + 6'd0;
  localparam logic [5:0] OP_GT   = GROUP_CMP + 6'd1;
  localparam logic [5:0] OP_LE   = GROUP_CMP + 6'd2;
  localparam logic [5:0] OP_GE   = GROUP_CMP + 6'd3;
  localparam logic [5:0] OP_EQ   = GROUP_CMP + 6'd4;
  localparam logic [5:0] OP_NE   = GROUP_CMP + 6'd5;
  localparam logic [5:0] OP_LAND = GROUP_CMP + 6'd6;
  localparam logic [5:0] OP_LOR  = GROUP_CMP + 6'd7;
  localparam logic [5:0] OP_LD8  = GROUP_MEM + 6'd7;
  localparam logic [5:0] OP_ST8  = GROUP_MEM + 6'd15;
  localparam logic [5:0] OP_JLT  = GROUP_JMP + 6'd0;
  localparam logic [5:0] OP_JGT  = GROUP_JMP + 6'd1;
  localparam logic [5:0] OP_JLE  = GROUP_JMP + 6'd2;
  localparam logic [5:0] OP_JGE  = GROUP_JMP + 6'd3;
  localparam logic [5:0] OP_JEQ  = GROUP_JMP + 6'd4;
  localparam logic [5:0] OP_JNE  = GROUP_JMP + 6'd5;
  localparam logic [5:0] OP_JMP  = GROUP_JMP + 6'd6;

  localparam logic [1:0] FAULT_OK     = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_DIV0   = 2'd2;
  localparam logic [1:0] FAULT_ADDR   = 2'd3;

  typedef struct packed {
    logic start;
    logic div;
    logic rem;
  } md_ctl_t;

  typedef struct packed {
    logic re;
    logic we;
  } dm_req_t;

endpackage

[hw/rtl/rvie_in_if.sv]
interface rvie_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [5:0]  opcode;
  logic [7:0]  dest_reg;
  logic [7:0]  src_reg_a;
  logic [7:0]  src_reg_b;
  logic signed [31:0] imm;

  modport source (output valid, pc, opcode, dest_reg, src_reg_a, src_reg_b, imm,
                  input ready);
  modport sink (input valid, pc, opcode, dest_reg, src_reg_a, src_reg_b, imm,
                output ready);
endinterface

[hw/rtl/rvie_out_if.sv]
interface rvie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [1:0]  fault;
  logic        reg_written;
  logic signed [63:0] write_value;

  modport source (output valid, next_pc, fault, reg_written, write_value,
                  input ready);
  modport sink (input valid, next_pc, fault, reg_written, write_value,
                output ready);
endinterface

[hw/rtl/rvie_regfile.sv]
module rvie_regfile #(
  parameter int REG_COUNT = 256,
  localparam int RW = $clog2(REG_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [RW-1:0] raddr,
  output logic [63:0]   rdata,
  input  logic          we,
  input  logic [RW-1:0] waddr,
  input  logic [63:0]   wdata
);

  logic [63:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [63:0]          q_r;
  logic                 qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      qv_r <= vld_r[raddr];
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

[hw/rtl/rvie_dmem.sv]
module rvie_dmem
  import rvie_pkg::*;
#(
  parameter int MEM_WORDS = 16384,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dm_req_t       req,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata,
  output logic          clr_busy
);

  logic [63:0]   mem [MEM_WORDS];
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_busy_r, clr_busy_nxt;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.we) begin
      mem[addr] <= wdata;
    end
    if (req.re) begin
      rdata <= mem[addr];
    end
  end

  assign clr_busy = clr_busy_r;

endmodule

[hw/rtl/rvie_muldiv.sv]
module rvie_muldiv
  import rvie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  md_ctl_t     ctl,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic        run_r, fin_r, div_r, rem_r, negq_r, nega_r;
  logic [6:0]  cnt_r;
  logic [63:0] acc_r, dvd_r, dvs_r, ma_r, mb_r;
  logic [31:0] mop_a, mop_b;
  logic [63:0] prod;
  logic [64:0] rem_sh, diff;

  // low 64 bits of the product: al*bl + (al*bh + ah*bl) << 32, one partial a cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin mop_a = ma_r[31:0];  mop_b = mb_r[31:0];  end
      2'd1:    begin mop_a = ma_r[31:0];  mop_b = mb_r[63:32]; end
      default: begin mop_a = ma_r[63:32]; mop_b = mb_r[31:0];  end
    endcase
  end
  assign prod = mop_a * mop_b;

  assign rem_sh = {acc_r, dvd_r[63]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      fin_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
        if ((!div_r && cnt_r == 7'd2) || (div_r && cnt_r == 7'd63)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      div_r  <= ctl.div;
      rem_r  <= ctl.rem;
      ma_r   <= a;
      mb_r   <= b;
      negq_r <= a[63] ^ b[63];
      nega_r <= a[63];
      dvd_r  <= a[63] ? -a : a;
      dvs_r  <= b[63] ? -b : b;
      acc_r  <= '0;
    end else if (run_r) begin
      if (div_r) begin
        if (!diff[64]) begin
          acc_r <= diff[63:0];
          dvd_r <= {dvd_r[62:0], 1'b1};
        end else begin
          acc_r <= rem_sh[63:0];
          dvd_r <= {dvd_r[62:0], 1'b0};
        end
      end else if (cnt_r == 7'd0) begin
        acc_r <= prod;
      end else begin
        acc_r <= acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  always_comb begin
    if (!div_r) begin
      result = acc_r;
    end else if (rem_r) begin
      result = nega_r ? -acc_r : acc_r;
    end else begin
      result = negq_r ? -dvd_r : dvd_r;
    end
  end

  assign done = fin_r;

endmodule

[hw/rtl/register_vm_instruction_execute.sv]
// Channel | Port   | Dir | Payload
// input   | in_ch  | in  | pc, opcode, dest_reg, src_reg_a, src_reg_b, imm
// result  | out_ch | out | next_pc, fault, reg_written, write_value
//
// One instruction at a time: three register file reads (one read port),
// execute and write-back; mul forms three 32x32 partial products, div/mod
// run a radix-2 loop and ld8 adds a data memory read state. After reset the
// data memory is swept to zero, word by word, with in_ch.ready low. A
// result waits in the output register; write-back of the following
// instruction stalls until that register is free.
module register_vm_instruction_execute
  import rvie_pkg::*;
#(
  parameter int REG_COUNT = 256,
  parameter int MEM_WORDS = 16384
) (
  input logic      clk,
  input logic      rst_n,
  rvie_in_if.sink  in_ch,
  rvie_out_if.source out_ch
);

  localparam int RW = $clog2(REG_COUNT);
  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDD  = 8'b0000_0010,
    S_RDA  = 8'b0000_0100,
    S_RDB  = 8'b0000_1000,
    S_EXEC = 8'b0001_0000,
    S_MD   = 8'b0010_0000,
    S_LD   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] pc_r;
  logic [5:0]  op_r;
  logic [7:0]  rd_r, ra_r, rb_r;
  logic [31:0] imm_r;
  logic [63:0] d_r, a_r;

  logic [15:0] npc_r, npc_nxt;
  logic [1:0]  fault_r, fault_nxt;
  logic        wr_r, wr_nxt;
  logic [63:0] val_r, val_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] o_npc_r;
  logic [1:0]  o_fault_r;
  logic        o_wr_r;
  logic [63:0] o_val_r;

  logic [RW-1:0] rf_raddr;
  logic [63:0]   rf_rdata;
  logic          rf_we;

  dm_req_t     dm_req;
  logic [63:0] dm_rdata;
  logic        clr_busy;

  md_ctl_t     md_ctl;
  logic        md_done;
  logic [63:0] md_res;

  logic        in_acc, out_free, rd_ok, ra_ok, rb_ok, take;
  logic [63:0] b_w, imm64, addr, shl_v, shr_v;
  logic [15:0] pc1;
  logic        addr_ok;

  function automatic logic reg_ok(input logic [7:0] n);
    return {1'b0, n} < 9'(REG_COUNT);
  endfunction

  assign rd_ok = reg_ok(rd_r);
  assign ra_ok = reg_ok(ra_r);
  assign rb_ok = reg_ok(rb_r);

  assign in_ch.ready = (state_r == S_IDLE) && !clr_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    case (state_r)
      S_RDA:   rf_raddr = ra_r[RW-1:0];
      S_RDB:   rf_raddr = rb_r[RW-1:0];
      default: rf_raddr = rd_r[RW-1:0];
    endcase
  end

  // B arrives from the register file in the execute cycle itself
  assign b_w     = rb_ok ? rf_rdata : '0;
  assign imm64   = {{32{imm_r[31]}}, imm_r};
  assign addr    = a_r + b_w + imm64;
  assign addr_ok = addr < 64'(MEM_WORDS);
  assign shl_v   = a_r << imm_r[5:0];
  assign shr_v   = 64'($signed(a_r) >>> imm_r[5:0]);
  assign pc1     = pc_r + 16'd1;

  always_comb begin
    case (op_r)
      OP_JLT:  take = d_r[63];
      OP_JGT:  take = !d_r[63] && (d_r != '0);
      OP_JLE:  take = d_r[63] || (d_r == '0);
      OP_JGE:  take = !d_r[63];
      OP_JEQ:  take = d_r == '0;
      OP_JNE:  take = d_r != '0;
      OP_JMP:  take = 1'b1;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    npc_nxt   = npc_r;
    fault_nxt = fault_r;
    wr_nxt    = wr_r;
    val_nxt   = val_r;
    md_ctl    = '0;
    dm_req    = '0;
    rf_we     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RDD;
      S_RDD:  state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_EXEC;
      S_EXEC: begin
        npc_nxt   = take ? addr[15:0] : pc1;
        fault_nxt = FAULT_OK;
        wr_nxt    = 1'b1;
        val_nxt   = '0;
        state_nxt = S_DONE;
        case (op_r)
          OP_ADD: val_nxt = a_r + b_w;
          OP_SUB: val_nxt = a_r - b_w;
          OP_AND, OP_LAND: val_nxt = a_r & b_w;
          OP_OR, OP_LOR:   val_nxt = a_r | b_w;
          OP_XOR: val_nxt = a_r ^ b_w;
          OP_SHL: val_nxt = shl_v;
          OP_SHR: val_nxt = shr_v;
          OP_LT:  val_nxt = 64'($signed(a_r) <  $signed(b_w));
          OP_GT:  val_nxt = 64'($signed(a_r) >  $signed(b_w));
          OP_LE:  val_nxt = 64'($signed(a_r) <= $signed(b_w));
          OP_GE:  val_nxt = 64'($signed(a_r) >= $signed(b_w));
          OP_EQ:  val_nxt = 64'(a_r == b_w);
          OP_NE:  val_nxt = 64'(a_r != b_w);
          OP_MUL: begin
            md_ctl.start = 1'b1;
            state_nxt    = S_MD;
          end
          OP_DIV, OP_MOD: begin
            if (b_w == '0) begin
              fault_nxt = FAULT_DIV0;
              wr_nxt    = 1'b0;
            end else begin
              md_ctl.start = 1'b1;
              md_ctl.div   = 1'b1;
              md_ctl.rem   = op_r == OP_MOD;
              state_nxt    = S_MD;
            end
          end
          OP_LD8: begin
            if (!addr_ok) begin
              fault_nxt = FAULT_ADDR;
              wr_nxt    = 1'b0;
            end else begin
              dm_req.re = 1'b1;
              state_nxt = S_LD;
            end
          end
          OP_ST8: begin
            wr_nxt = 1'b0;
            if (!addr_ok) begin
              fault_nxt = FAULT_ADDR;
            end else begin
              dm_req.we = 1'b1;
              val_nxt   = d_r;
            end
          end
          OP_JLT, OP_JGT, OP_JLE, OP_JGE, OP_JEQ, OP_JNE, OP_JMP: wr_nxt = 1'b0;
          default: begin
            fault_nxt = FAULT_OPCODE;
            wr_nxt    = 1'b0;
          end
        endcase
        if (wr_nxt && !rd_ok) begin
          wr_nxt  = 1'b0;
          val_nxt = '0;
        end
      end
      S_MD: begin
        if (md_done) begin
          val_nxt   = rd_ok ? md_res : '0;
          state_nxt = S_DONE;
        end
      end
      S_LD: begin
        val_nxt   = rd_ok ? dm_rdata : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          rf_we         = wr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_r        <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    npc_r   <= npc_nxt;
    fault_r <= fault_nxt;
    val_r   <= val_nxt;
    if (in_acc) begin
      pc_r  <= in_ch.pc;
      op_r  <= in_ch.opcode;
      rd_r  <= in_ch.dest_reg;
      ra_r  <= in_ch.src_reg_a;
      rb_r  <= in_ch.src_reg_b;
      imm_r <= in_ch.imm;
    end
    if (state_r == S_RDA) d_r <= rd_ok ? rf_rdata : '0;
    if (state_r == S_RDB) a_r <= ra_ok ? rf_rdata : '0;
    if (state_r == S_DONE && out_free) begin
      o_npc_r   <= npc_r;
      o_fault_r <= fault_r;
      o_wr_r    <= wr_r;
      o_val_r   <= val_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_pc     = o_npc_r;
  assign out_ch.fault       = o_fault_r;
  assign out_ch.reg_written = o_wr_r;
  assign out_ch.write_value = o_val_r;

  rvie_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (rf_raddr),
    .rdata (rf_rdata),
    .we    (rf_we),
    .waddr (rd_r[RW-1:0]),
    .wdata (val_r)
  );

  rvie_dmem #(.MEM_WORDS(MEM_WORDS)) u_dm (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dm_req),
    .addr     (addr[AW-1:0]),
    .wdata    (d_r),
    .rdata    (dm_rdata),
    .clr_busy (clr_busy)
  );

  rvie_muldiv u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (md_ctl),
    .a      (a_r),
    .b      (b_w),
    .done   (md_done),
    .result (md_res)
  );

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.fault != FAULT_OK) |-> !out_ch.reg_written)
    else $error("faulting instruction reports a register write");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_RDD)
    else $error("accepted instruction did not start register reads");

  a_rf_write_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (state_r == S_DONE) && rd_ok && out_free)
    else $error("register file written outside write-back");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (state_r == S_IDLE) && !dm_req.we && !dm_req.re)
    else $error("data memory accessed during clearing pass");

endmodule
